[rtl/core/icmp_pkg.sv]
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Shared codes, widths and control types for the echo responder core.
// ----------------------------------------------------------------------------
package icmp_pkg;

    // Default largest packet held in the packet store
    localparam int MAX_PACKET_DEF = 1500;

    // Shortest packet that carries a full ICMP header
    localparam int MIN_PACKET = 8;

    // Width of the reply length field on the result channel
    localparam int REPLY_LEN_W = 11;

    // Type/code word of an echo request
    localparam logic [15:0] ECHO_REQUEST_WORD = 16'h0800;

    // Input item kinds
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    // Result kinds
    typedef enum logic [2:0] {
        VERDICT_READY      = 3'd0,
        VERDICT_SHORT      = 3'd1,
        VERDICT_LONG       = 3'd2,
        VERDICT_BAD_SUM    = 3'd3,
        VERDICT_NOT_ECHO   = 3'd4,
        VERDICT_REPLY_BYTE = 3'd5,
        VERDICT_NONE       = 3'd6
    } verdict_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic push;          // store and sum one packet byte
        logic close;         // the pushed byte ends the packet
        logic pull;          // step the reply read pointer, issue store read
        logic load_verdict;  // load the end-of-packet verdict word
        logic load_pull;     // load the reply byte word
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;      // output register empty or draining this cycle
    } dp_status_t;

endpackage

[rtl/core/icmp_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1500
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on request, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/icmp_ctrl.sv]
// ----------------------------------------------------------------------------
// ICMP echo responder controller
// Accepts input words and sequences verdict and reply byte generation.
// ----------------------------------------------------------------------------
module icmp_ctrl import icmp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_func,
    input  logic       item_last,
    output logic       item_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode the state into commands
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_func == FUNC_PULL)
                    begin
                        cmd.pull   = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.push  = 1'b1;
                        cmd.close = item_last;
                        if (item_last)
                        begin
                            state_next = ST_EVAL;
                        end
                    end
                end
            end
            ST_EVAL:
            begin
                // hold until the output register can take the verdict
                if (status.out_free)
                begin
                    cmd.load_verdict = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // store data is valid now; hold until the output is free
                if (status.out_free)
                begin
                    cmd.load_pull = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/icmp_datapath.sv]
// ----------------------------------------------------------------------------
// ICMP echo responder datapath
// Packet store, running checksum, header captures, reply pointer and the
// output register.
// ----------------------------------------------------------------------------
module icmp_datapath import icmp_pkg::*; #(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [7:0]             data_byte,
    input  logic [31:0]            source_addr,
    input  logic                   out_ready,
    output logic                   out_valid,
    output verdict_t               verdict,
    output logic [REPLY_LEN_W-1:0] reply_length,
    output logic [7:0]             reply_byte,
    output logic                   reply_last,
    output logic [31:0]            reply_dest
);

    // Count holds MAX_PACKET + 1 and is at least as wide as the length field
    localparam int CNT_BITS = $clog2(MAX_PACKET + 2);
    localparam int CW = (CNT_BITS > REPLY_LEN_W) ? CNT_BITS : REPLY_LEN_W;
    localparam int AW = $clog2(MAX_PACKET);
    localparam int SW = CW + 16;

    // One's-complement fold and complement; the high part is narrow, so two
    // additions close every carry
    function automatic logic [15:0] fold_not(input logic [SW-1:0] s);
        logic [16:0] part;
        logic [15:0] folded;
        part   = {1'b0, s[15:0]} + 17'(s[SW-1:16]);
        folded = part[15:0] + 16'(part[16]);
        return ~folded;
    endfunction

    logic [CW-1:0] count_reg,   count_next;
    logic [SW-1:0] sum_reg,     sum_next;
    logic [15:0]   fw_reg,      fw_next;
    logic [15:0]   rx_reg,      rx_next;
    logic          pending_reg, pending_next;
    logic [CW-1:0] rp_reg,      rp_next;
    logic [31:0]   addr_reg,    addr_next;
    logic          closed_reg,  closed_next;
    logic          out_valid_reg, out_valid_next;

    logic          pull_ok_reg,    pull_ok_next;
    logic          pull_last_reg,  pull_last_next;
    logic          pull_small_reg, pull_small_next;
    logic [1:0]    pull_lo_reg,    pull_lo_next;

    verdict_t               out_verdict_reg, out_verdict_next;
    logic [REPLY_LEN_W-1:0] out_len_reg,     out_len_next;
    logic [7:0]             out_byte_reg,    out_byte_next;
    logic                   out_last_reg,    out_last_next;
    logic [31:0]            out_dest_reg,    out_dest_next;

    logic [CW-1:0] push_pos;
    logic          push_in_range;
    logic [15:0]   check_sum;
    logic [15:0]   reply_sum;
    logic [7:0]    ram_rdata;

    // A push after the end byte starts a new packet at position zero
    assign push_pos      = closed_reg ? '0 : count_reg;
    assign push_in_range = push_pos < CW'(MAX_PACKET);

    assign check_sum = fold_not(sum_reg + SW'(fw_reg));
    assign reply_sum = fold_not(sum_reg);

    assign status.out_free = !out_valid_reg || out_ready;

    // Packet store
    icmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PACKET)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push && push_in_range),
        .wr_addr (push_pos[AW-1:0]),
        .wr_data (data_byte),
        .rd_en   (cmd.pull),
        .rd_addr (rp_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // Next-state logic for packet state and output word
    always_comb
    begin
        count_next       = count_reg;
        sum_next         = sum_reg;
        fw_next          = fw_reg;
        rx_next          = rx_reg;
        pending_next     = pending_reg;
        rp_next          = rp_reg;
        addr_next        = addr_reg;
        closed_next      = closed_reg;
        pull_ok_next     = pull_ok_reg;
        pull_last_next   = pull_last_reg;
        pull_small_next  = pull_small_reg;
        pull_lo_next     = pull_lo_reg;
        out_verdict_next = out_verdict_reg;
        out_len_next     = out_len_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_dest_next    = out_dest_reg;

        // Push: capture header words, sum the body, saturate the count
        if (cmd.push)
        begin
            if (closed_reg)
            begin
                count_next   = '0;
                sum_next     = '0;
                fw_next      = '0;
                rx_next      = '0;
                pending_next = 1'b0;
                rp_next      = '0;
            end
            if (push_in_range)
            begin
                if (push_pos == CW'(0))
                begin
                    fw_next[15:8] = data_byte;
                end
                else if (push_pos == CW'(1))
                begin
                    fw_next[7:0] = data_byte;
                end
                else if (push_pos == CW'(2))
                begin
                    rx_next[15:8] = data_byte;
                end
                else if (push_pos == CW'(3))
                begin
                    rx_next[7:0] = data_byte;
                end
                else if (push_pos[0])
                begin
                    sum_next = sum_next + SW'(data_byte);
                end
                else
                begin
                    sum_next = sum_next + SW'({data_byte, 8'h00});
                end
                count_next = push_pos + CW'(1);
            end
            else
            begin
                count_next = CW'(MAX_PACKET + 1);
            end
            closed_next = cmd.close;
            if (cmd.close)
            begin
                addr_next = source_addr;
            end
        end

        // Pull: check for a pending byte and step the pointer
        if (cmd.pull)
        begin
            pull_ok_next    = pending_reg && (rp_reg < count_reg)
                              && (count_reg <= CW'(MAX_PACKET));
            pull_last_next  = (rp_reg + CW'(1)) == count_reg;
            pull_small_next = rp_reg < CW'(4);
            pull_lo_next    = rp_reg[1:0];
            if (pull_ok_next)
            begin
                rp_next = rp_reg + CW'(1);
                if (pull_last_next)
                begin
                    pending_next = 1'b0;
                end
            end
        end

        // End-of-packet verdict
        if (cmd.load_verdict)
        begin
            out_len_next  = '0;
            out_byte_next = '0;
            out_last_next = 1'b0;
            out_dest_next = '0;
            if (count_reg < CW'(MIN_PACKET))
            begin
                out_verdict_next = VERDICT_SHORT;
            end
            else if (count_reg > CW'(MAX_PACKET))
            begin
                out_verdict_next = VERDICT_LONG;
            end
            else if (check_sum != rx_reg)
            begin
                out_verdict_next = VERDICT_BAD_SUM;
            end
            else if (fw_reg != ECHO_REQUEST_WORD)
            begin
                out_verdict_next = VERDICT_NOT_ECHO;
            end
            else
            begin
                out_verdict_next = VERDICT_READY;
                out_len_next     = count_reg[REPLY_LEN_W-1:0];
                out_dest_next    = addr_reg;
                pending_next     = 1'b1;
                rp_next          = '0;
            end
        end

        // Reply byte: zeroed type/code, new checksum, then stored body
        if (cmd.load_pull)
        begin
            if (pull_ok_reg)
            begin
                out_verdict_next = VERDICT_REPLY_BYTE;
                out_len_next     = count_reg[REPLY_LEN_W-1:0];
                out_last_next    = pull_last_reg;
                out_dest_next    = addr_reg;
                if (!pull_small_reg)
                begin
                    out_byte_next = ram_rdata;
                end
                else if (pull_lo_reg == 2'd2)
                begin
                    out_byte_next = reply_sum[15:8];
                end
                else if (pull_lo_reg == 2'd3)
                begin
                    out_byte_next = reply_sum[7:0];
                end
                else
                begin
                    out_byte_next = 8'h00;
                end
            end
            else
            begin
                out_verdict_next = VERDICT_NONE;
                out_len_next     = '0;
                out_byte_next    = '0;
                out_last_next    = 1'b0;
                out_dest_next    = '0;
            end
        end

        // Output register: fill on load, drop when taken
        if (cmd.load_verdict || cmd.load_pull)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Packet and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            fw_reg        <= '0;
            rx_reg        <= '0;
            pending_reg   <= 1'b0;
            rp_reg        <= '0;
            addr_reg      <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            fw_reg        <= fw_next;
            rx_reg        <= rx_next;
            pending_reg   <= pending_next;
            rp_reg        <= rp_next;
            addr_reg      <= addr_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pull_ok_reg     <= pull_ok_next;
        pull_last_reg   <= pull_last_next;
        pull_small_reg  <= pull_small_next;
        pull_lo_reg     <= pull_lo_next;
        out_verdict_reg <= out_verdict_next;
        out_len_reg     <= out_len_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
        out_dest_reg    <= out_dest_next;
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = out_verdict_reg;
    assign reply_length = out_len_reg;
    assign reply_byte   = out_byte_reg;
    assign reply_last   = out_last_reg;
    assign reply_dest   = out_dest_reg;

endmodule

[rtl/core/icmp_echo_responder_top.sv]
// ----------------------------------------------------------------------------
// ICMP echo responder
// Checks incoming ICMP messages and serves echo replies byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per item: tuser selects push (0) or
//   pull (1), tdata holds the message byte and the source address, tlast
//   marks the final pushed byte. The master stream returns one word per
//   end byte and per pull: tuser is the verdict, tlast marks the final
//   reply byte.
//   Plain pushes without tlast are taken back to back. An end byte or a
//   pull is followed by a result step before the next item is taken; at
//   its end the verdict word, or the reply byte from the registered read
//   of the packet store that the pull issued, is loaded into the output
//   register and tvalid rises.
//   A waiting result does not block plain pushes; an end byte or a pull
//   holds in its result step, with tready low, while the output register
//   is still full.
//   Reset clears the counts, sums, captures and any pending reply; the
//   packet store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module icmp_echo_responder_top import icmp_pkg::*; #(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_byte[7:0], source_addr[39:8]
    input  logic        s_axis_tuser,   // func[0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // reply_length[10:0], reply_byte[18:11],
                                        // reply_dest[50:19], zero[55:51]
    output logic [2:0]  m_axis_tuser,   // verdict[2:0]
    output logic        m_axis_tlast
);

    localparam int PAD_W = 56 - (REPLY_LEN_W + 8 + 32);

    ctrl_cmd_t              cmd;
    dp_status_t             status;
    verdict_t               verdict;
    logic [REPLY_LEN_W-1:0] reply_length;
    logic [7:0]             reply_byte;
    logic [31:0]            reply_dest;

    // Sequencer
    icmp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_axis_tvalid),
        .item_func  (s_axis_tuser),
        .item_last  (s_axis_tlast),
        .item_ready (s_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // Store, checksum and output register
    icmp_datapath #(
        .MAX_PACKET (MAX_PACKET)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .data_byte    (s_axis_tdata[7:0]),
        .source_addr  (s_axis_tdata[39:8]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .verdict      (verdict),
        .reply_length (reply_length),
        .reply_byte   (reply_byte),
        .reply_last   (m_axis_tlast),
        .reply_dest   (reply_dest)
    );

    assign m_axis_tuser = verdict;
    assign m_axis_tdata = {{PAD_W{1'b0}}, reply_dest, reply_byte, reply_length};

`ifndef SYNTH
    // A word is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_verdict || cmd.load_pull) |-> status.out_free)
        else $error("result loaded over an untaken word");

    // A loaded word shows on the master side
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_verdict || cmd.load_pull) |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // An end byte or a pull holds the slave side for its result step
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready
         && (s_axis_tuser == FUNC_PULL || s_axis_tlast)) |=> !s_axis_tready)
        else $error("input accepted during result step");

    // A plain push leaves the block ready for the next byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready
         && s_axis_tuser == FUNC_PUSH && !s_axis_tlast) |=> s_axis_tready)
        else $error("plain push stalled the input");
`endif

endmodule

[tb/icmp_echo_responder_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo responder testbench
// Drives message bytes and reply pulls into the responder and checks every
// verdict and reply word against an in-bench model of the packet store,
// the one's-complement sums and the reply read-out. A short table of fixed
// words comes first, then random packets: good echo requests, corrupted
// checksums, other types, runts and one oversize packet.
// ----------------------------------------------------------------------------
module icmp_echo_responder_top_tb import icmp_pkg::*; ();

    localparam int MAX_PKT      = MAX_PACKET_DEF;
    localparam int ITEMS        = 1950;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_NS     = 4_000_000;

    // One result word as it leaves the block
    typedef struct packed {
        verdict_t    verdict;
        logic [10:0] len;
        logic [7:0]  data;
        logic        last;
        logic [31:0] dest;
    } echo_word_t;

    // One row of the opening table; want is used only where typed is set
    typedef struct packed {
        logic        func;
        logic [7:0]  data;
        logic        eop;
        logic [31:0] src;
        bit          typed;
        echo_word_t  want;
    } stim_row_t;

    typedef enum int {
        PK_ECHO,
        PK_BAD_SUM,
        PK_NOT_ECHO,
        PK_SHORT,
        PK_LONG
    } pkt_kind_t;

    localparam echo_word_t W_NONE     = '{VERDICT_NONE, 11'd0, 8'd0, 1'b0, 32'd0};
    localparam echo_word_t W_SHORT    = '{VERDICT_SHORT, 11'd0, 8'd0, 1'b0, 32'd0};
    localparam echo_word_t W_NOT_ECHO = '{VERDICT_NOT_ECHO, 11'd0, 8'd0, 1'b0, 32'd0};
    localparam echo_word_t W_READY8   = '{VERDICT_READY, 11'd8, 8'd0, 1'b0, 32'hFFFF_FFFF};

    // Pull on an empty block, a one-byte runt, a minimal echo request read out
    // in full plus one pull too many, then a packet of another type, all ones but for its zero checksum
    localparam stim_row_t OPENING_ROWS [27] = '{
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b1, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b1, 32'hA5A5_5A5A, 1'b1, W_SHORT},
        '{FUNC_PUSH, 8'h08, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hF7, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, W_READY8},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PULL, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'h00, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b0, 32'h0000_0000, 1'b0, W_NONE},
        '{FUNC_PUSH, 8'hFF, 1'b1, 32'h0000_0000, 1'b1, W_NOT_ECHO}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // data_byte[7:0], source_addr[39:8]
    logic        s_axis_tuser = 1'b0;   // func[0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // reply_length[10:0], reply_byte[18:11],
                                        // reply_dest[50:19], zero[55:51]
    logic [2:0]  m_axis_tuser;          // verdict[2:0]
    logic        m_axis_tlast;

    // Model state of the responder
    logic [7:0]  pkt_mem [MAX_PKT];
    int unsigned pkt_len = 0;
    logic [31:0] word_sum = '0;
    logic [15:0] hdr_word = '0;
    logic [15:0] rx_csum = '0;
    bit          reply_armed = 1'b0;
    int unsigned rd_idx = 0;
    logic [31:0] dest_addr = '0;
    bit          pkt_done = 1'b0;

    echo_word_t  due_words [$];
    int          fail_count = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          budget_items = 0;
    int          verdict_seen [7] = '{default: 0};

    icmp_echo_responder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Fold a sum to 16 bits with end-around carry and invert it
    function automatic logic [15:0] ones_fold_inv(input logic [31:0] s);
        logic [31:0] t;
        t = s;
        while (t[31:16] != 16'd0)
            t = t[15:0] + t[31:16];
        return ~t[15:0];
    endfunction

    // Advance the model by one accepted word; return 1 when a result is due
    function automatic bit predict_echo(input logic f, input logic [7:0] b,
                                        input logic eop, input logic [31:0] src,
                                        output echo_word_t w);
        int unsigned p;
        logic [15:0] ck;
        w = W_NONE;
        if (f == FUNC_PUSH)
        begin
            // the first byte after an end byte opens a fresh packet
            if (pkt_done)
            begin
                pkt_len = 0;
                word_sum = '0;
                hdr_word = '0;
                rx_csum = '0;
                reply_armed = 1'b0;
                rd_idx = 0;
                pkt_done = 1'b0;
            end
            p = pkt_len;
            if (p < MAX_PKT)
            begin
                pkt_mem[p] = b;
                case (p)
                    0: hdr_word[15:8] = b;
                    1: hdr_word[7:0] = b;
                    2: rx_csum[15:8] = b;
                    3: rx_csum[7:0] = b;
                    default: word_sum += (p % 2 == 0) ? {b, 8'h00} : {8'h00, b};
                endcase
                pkt_len = p + 1;
            end
            else
            begin
                pkt_len = MAX_PKT + 1;
            end
            if (!eop)
                return 1'b0;
            pkt_done = 1'b1;
            if (pkt_len < MIN_PACKET)
                w.verdict = VERDICT_SHORT;
            else if (pkt_len > MAX_PKT)
                w.verdict = VERDICT_LONG;
            else if (ones_fold_inv(word_sum + hdr_word) != rx_csum)
                w.verdict = VERDICT_BAD_SUM;
            else if (hdr_word != ECHO_REQUEST_WORD)
                w.verdict = VERDICT_NOT_ECHO;
            else
            begin
                reply_armed = 1'b1;
                rd_idx = 0;
                dest_addr = src;
                w.verdict = VERDICT_READY;
                w.len = 11'(pkt_len);
                w.dest = src;
            end
            return 1'b1;
        end
        if (!reply_armed || rd_idx >= pkt_len || pkt_len > MAX_PKT)
            return 1'b1;
        // reply: zeroed type and code, fresh checksum, then the stored body
        ck = ones_fold_inv(word_sum);
        w.verdict = VERDICT_REPLY_BYTE;
        w.len = 11'(pkt_len);
        w.dest = dest_addr;
        w.last = (rd_idx + 1 == pkt_len);
        if (rd_idx < 2)
            w.data = 8'h00;
        else if (rd_idx == 2)
            w.data = ck[15:8];
        else if (rd_idx == 3)
            w.data = ck[7:0];
        else
            w.data = pkt_mem[rd_idx];
        rd_idx++;
        if (w.last)
            reply_armed = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one word, idling at random first, and log its expectation on accept
    task automatic send_word(input logic f, input logic [7:0] b, input logic eop,
                             input logic [31:0] src, input bit use_want,
                             input echo_word_t want);
        echo_word_t w;
        bit         due;
        while (!(budget_items >= 800 && budget_items < 1100)
               && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {src, b};
        s_axis_tuser  <= f;
        s_axis_tlast  <= eop;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        due = predict_echo(f, b, eop, src, w);
        if (due)
            due_words.push_back(use_want ? want : w);
        words_in++;
        budget_items++;
    endtask

    // Hold the input idle until every expected word has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
    endtask

    // Build one packet of the given kind, push it, then pull some of its reply
    task automatic send_packet(input pkt_kind_t kind, input int len, input bit big);
        logic [7:0]  body [$];
        logic [31:0] acc;
        logic [15:0] ck;
        int          idx;
        int          pulls;
        int          pick;
        for (int i = 0; i < len; i++)
            body.push_back(8'($urandom_range(255)));
        if (kind != PK_SHORT)
        begin
            if (kind == PK_NOT_ECHO)
            begin
                do
                begin
                    body[0] = 8'($urandom_range(255));
                    body[1] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
                end
                while ({body[0], body[1]} == ECHO_REQUEST_WORD);
            end
            else
            begin
                body[0] = ECHO_REQUEST_WORD[15:8];
                body[1] = ECHO_REQUEST_WORD[7:0];
            end
            acc = {16'h0000, body[0], body[1]};
            for (int i = 4; i < len && i < MAX_PKT; i++)
                acc += (i % 2 == 0) ? {body[i], 8'h00} : {8'h00, body[i]};
            ck = ones_fold_inv(acc);
            body[2] = ck[15:8];
            body[3] = ck[7:0];
            // flip one bit anywhere past the type and code
            if (kind == PK_BAD_SUM)
            begin
                idx = $urandom_range(len - 1, 2);
                body[idx] ^= 8'h01 << $urandom_range(7);
            end
        end
        for (int i = 0; i < len; i++)
        begin
            // now and then a stray pull while the packet is still arriving
            if (i > 0 && !big && $urandom_range(99) < 4)
                send_word(FUNC_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          $urandom, 1'b0, W_NONE);
            send_word(FUNC_PUSH, body[i], i == len - 1, $urandom, 1'b0, W_NONE);
        end
        pick = $urandom_range(99);
        if (big)
            pulls = 1 + $urandom_range(2);
        else if (pick < 75)
            pulls = len + $urandom_range(2);
        else if (pick < 90)
            pulls = $urandom_range(len - 1);
        else
            pulls = $urandom_range(3);
        for (int i = 0; i < pulls; i++)
            send_word(FUNC_PULL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom, 1'b0, W_NONE);
    endtask

    // Result side: check each word taken, stall at random, one long hold-off
    initial
    begin : result_sink
        echo_word_t w;
        int         hold_left;
        bit         held_off;
        hold_left = 0;
        held_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                if (due_words.size() == 0)
                begin
                    $error("result word 0x%0h with verdict %0d and none expected",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    w = due_words.pop_front();
                    check_field("verdict", 32'(w.verdict), 32'(m_axis_tuser));
                    check_field("reply_length", 32'(w.len), 32'(m_axis_tdata[10:0]));
                    check_field("reply_byte", 32'(w.data), 32'(m_axis_tdata[18:11]));
                    check_field("reply_dest", w.dest, m_axis_tdata[50:19]);
                    check_field("reply_last", 32'(w.last), 32'(m_axis_tlast));
                    if (w.verdict <= VERDICT_NONE)
                        verdict_seen[w.verdict]++;
                end
                words_out++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!held_off && words_out >= 60)
            begin
                held_off = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= (words_out >= 80 && words_out < 150)
                                 || $urandom_range(99) >= 9;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int        episode;
        bit        paused;
        int        pick;
        pkt_kind_t kind;
        int        len;
        episode = 0;
        paused = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table
        foreach (OPENING_ROWS[i])
            send_word(OPENING_ROWS[i].func, OPENING_ROWS[i].data, OPENING_ROWS[i].eop,
                      OPENING_ROWS[i].src, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
        wait_for_results();

        // random packets, with one oversize packet early on
        while (budget_items < ITEMS)
        begin
            if (episode == 2)
                send_packet(PK_LONG, MAX_PKT + 1 + $urandom_range(3), 1'b1);
            else
            begin
                pick = $urandom_range(99);
                len = ($urandom_range(9) == 0) ? $urandom_range(200, 41)
                                               : $urandom_range(40, MIN_PACKET);
                if (pick < 62)
                    kind = PK_ECHO;
                else if (pick < 76)
                    kind = PK_BAD_SUM;
                else if (pick < 88)
                    kind = PK_NOT_ECHO;
                else
                begin
                    kind = PK_SHORT;
                    len = $urandom_range(MIN_PACKET - 1, 1);
                end
                send_packet(kind, len, 1'b0);
            end
            // pause once mid-run until the block has emptied
            if (!paused && budget_items >= ITEMS / 2)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            episode++;
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d words in and %0d words out over %0d packets",
                 words_in, words_out, episode + 3);
        $display("ready %0d, bytes %0d, short %0d, long %0d, bad sum %0d, other %0d, idle %0d",
                 verdict_seen[VERDICT_READY], verdict_seen[VERDICT_REPLY_BYTE],
                 verdict_seen[VERDICT_SHORT], verdict_seen[VERDICT_LONG],
                 verdict_seen[VERDICT_BAD_SUM], verdict_seen[VERDICT_NOT_ECHO],
                 verdict_seen[VERDICT_NONE]);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("timeout with %0d words still expected", due_words.size());
        $display("status: fail");
        $finish;
    end

endmodule
